// ----- hw/rtl/abma_pkg.sv -----
package abma_pkg;

	// Block and window sizes; HALF_BLOCK is a power of two
	localparam int HALF_BLOCK = 16;
	localparam int AVG_DEPTH  = 8;

	localparam int ADC_W  = 12;
	localparam int VOLT_W = 16;
	localparam int FS_W   = 16;
	localparam int CFG_W  = 16;

	localparam int HB_LOG = $clog2(HALF_BLOCK);
	localparam int CNT_W  = (HB_LOG > 0) ? HB_LOG : 1;
	localparam int ACC_W  = ADC_W + HB_LOG;

	localparam int AD_LOG = $clog2(AVG_DEPTH);
	localparam int POS_W  = (AD_LOG > 0) ? AD_LOG : 1;
	localparam int FILL_W = $clog2(AVG_DEPTH + 1);
	localparam int WSUM_W = ADC_W + AD_LOG;

	// Divider: dividend wide enough for avg * full_scale_mv
	localparam int DIV_W  = ADC_W + FS_W;
	localparam int STEP_W = $clog2(DIV_W + 1);

	// Register indexes
	localparam logic [1:0] CFG_FULL_SCALE = 2'd0;
	localparam logic [1:0] CFG_ADC_MAX    = 2'd1;
	localparam logic [1:0] CFG_OFFSET     = 2'd2;

	localparam logic [FS_W-1:0]   FULL_SCALE_RST = FS_W'(3300);
	localparam logic [ADC_W-1:0]  ADC_MAX_RST    = ADC_W'(4095);
	localparam logic [VOLT_W-1:0] OFFSET_RST     = VOLT_W'(400);
	localparam logic [VOLT_W-1:0] VOLT_SAT       = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_MUL,
		ST_SCALE_GO,
		ST_SCALE_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0]  dividend;
		logic [ADC_W-1:0]  divisor;
	} div_req_t;

endpackage

// ----- hw/rtl/abma_div.sv -----
module abma_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  abma_pkg::div_req_t              req,
	output logic                            busy,
	output logic [abma_pkg::DIV_W-1:0]      quotient
);

	logic [abma_pkg::STEP_W-1:0] steps_q;
	logic [abma_pkg::DIV_W-1:0]  quo_q;
	logic [abma_pkg::ADC_W-1:0]  rem_q;
	logic [abma_pkg::ADC_W-1:0]  dsr_q;
	logic                        busy_q;
	logic [abma_pkg::ADC_W:0]    rem_sh;
	logic [abma_pkg::ADC_W:0]    diff;
	logic                        ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh = {rem_q, quo_q[abma_pkg::DIV_W-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			steps_q <= req.steps;
		end else if (busy_q) begin
			steps_q <= steps_q - 1'b1;
			if (steps_q == abma_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[abma_pkg::ADC_W-1:0] : rem_sh[abma_pkg::ADC_W-1:0];
			quo_q <= {quo_q[abma_pkg::DIV_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ----- hw/rtl/abma_ring.sv -----
module abma_ring (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [abma_pkg::ADC_W-1:0]       mean,
	output logic [abma_pkg::WSUM_W-1:0]      window_sum,
	output logic [abma_pkg::FILL_W-1:0]      fill_count
);

	logic [abma_pkg::ADC_W-1:0]  hist_q [abma_pkg::AVG_DEPTH];
	logic [abma_pkg::POS_W-1:0]  pos_q;
	logic [abma_pkg::FILL_W-1:0] fill_q;
	logic [abma_pkg::WSUM_W-1:0] wsum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < abma_pkg::AVG_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			pos_q  <= '0;
			fill_q <= '0;
			wsum_q <= '0;
		end else if (push) begin
			// Drop the oldest mean from the window, add the new one
			wsum_q        <= wsum_q - abma_pkg::WSUM_W'(hist_q[pos_q])
			                 + abma_pkg::WSUM_W'(mean);
			hist_q[pos_q] <= mean;
			if (pos_q == abma_pkg::POS_W'(abma_pkg::AVG_DEPTH - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
			if (fill_q != abma_pkg::FILL_W'(abma_pkg::AVG_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign window_sum = wsum_q;
	assign fill_count = fill_q;

endmodule

// ----- hw/rtl/adc_block_and_moving_average_voltage.sv -----
// Boxcar decimator with moving average, scaled to millivolts. Samples are summed
// in blocks of HALF_BLOCK; each block mean enters a ring of AVG_DEPTH means whose
// sum is divided by the number of filled entries (fewer during warm-up), then
// multiplied by full_scale_mv, divided by adc_max, offset by offset_mv and
// saturated at 65535 (also 65535 when adc_max is zero). One voltage leaves per
// block. A sample that does not close a block is accepted without a stall. The
// sample that closes a block keeps s_tready low while one serial restoring
// divider, one quotient bit per cycle, runs twice (WSUM_W = 15 steps for the
// average, DIV_W = 28 steps for the scaling), plus a multiply and the
// sequencing states, and longer only while the previous voltage is still waiting
// on the master side. With adc_max zero the scaling division is skipped.
// Samples are accepted while a voltage waits to be taken.
module adc_block_and_moving_average_voltage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [abma_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [11:0] sample
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata    // [15:0] voltage_mv
);

	abma_pkg::state_t state_q, state_d;

	logic [abma_pkg::FS_W-1:0]   full_scale_q;
	logic [abma_pkg::ADC_W-1:0]  adc_max_q;
	logic [abma_pkg::VOLT_W-1:0] offset_q;

	logic [abma_pkg::ACC_W-1:0]  acc_q;
	logic [abma_pkg::ACC_W-1:0]  acc_next;
	logic [abma_pkg::CNT_W-1:0]  cnt_q;
	logic [abma_pkg::ADC_W-1:0]  mean_q;
	logic [abma_pkg::ADC_W-1:0]  avg_q;
	logic [abma_pkg::DIV_W-1:0]  prod_q;
	logic [abma_pkg::DIV_W-1:0]  prod_d;
	logic [abma_pkg::VOLT_W-1:0] volt_q;
	logic [abma_pkg::VOLT_W-1:0] volt_d;
	logic [abma_pkg::VOLT_W:0]   offs_sum;
	logic [abma_pkg::VOLT_W-1:0] m_tdata_q;
	logic                        m_tvalid_q;

	logic                        s_acc;
	logic                        last;
	logic                        push;
	logic                        load_out;
	abma_pkg::div_req_t          div_req;
	logic                        div_busy;
	logic [abma_pkg::DIV_W-1:0]  div_quo;
	logic [abma_pkg::WSUM_W-1:0] window_sum;
	logic [abma_pkg::FILL_W-1:0] fill_count;

	abma_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	abma_ring u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.mean       (mean_q),
		.window_sum (window_sum),
		.fill_count (fill_count)
	);

	assign s_acc    = s_tvalid && s_tready;
	assign last     = cnt_q == abma_pkg::CNT_W'(abma_pkg::HALF_BLOCK - 1);
	assign acc_next = acc_q + abma_pkg::ACC_W'(s_tdata[abma_pkg::ADC_W-1:0]);
	assign prod_d   = abma_pkg::DIV_W'(avg_q) * abma_pkg::DIV_W'(full_scale_q);
	assign offs_sum = {1'b0, div_quo[abma_pkg::VOLT_W-1:0]} + {1'b0, offset_q};

	// Saturate on a scaled value above 16 bits or on the offset overflowing
	always_comb begin
		if (div_quo[abma_pkg::DIV_W-1:abma_pkg::VOLT_W] != '0) begin
			volt_d = abma_pkg::VOLT_SAT;
		end else if (offs_sum[abma_pkg::VOLT_W]) begin
			volt_d = abma_pkg::VOLT_SAT;
		end else begin
			volt_d = offs_sum[abma_pkg::VOLT_W-1:0];
		end
	end

	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		push             = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.steps    = abma_pkg::STEP_W'(abma_pkg::DIV_W);
		div_req.dividend = prod_q;
		div_req.divisor  = adc_max_q;
		case (state_q)
			abma_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && last) begin
					state_d = abma_pkg::ST_PUSH;
				end
			end
			abma_pkg::ST_PUSH: begin
				push    = 1'b1;
				state_d = abma_pkg::ST_AVG_GO;
			end
			abma_pkg::ST_AVG_GO: begin
				// Window sum sits at the top of the dividend; run only its bits
				div_req.start    = 1'b1;
				div_req.steps    = abma_pkg::STEP_W'(abma_pkg::WSUM_W);
				div_req.dividend = {window_sum,
				                    {(abma_pkg::DIV_W - abma_pkg::WSUM_W){1'b0}}};
				div_req.divisor  = abma_pkg::ADC_W'(fill_count);
				state_d          = abma_pkg::ST_AVG_WAIT;
			end
			abma_pkg::ST_AVG_WAIT: begin
				if (!div_busy) begin
					state_d = abma_pkg::ST_MUL;
				end
			end
			abma_pkg::ST_MUL: begin
				if (adc_max_q == '0) begin
					state_d = abma_pkg::ST_FINISH;
				end else begin
					state_d = abma_pkg::ST_SCALE_GO;
				end
			end
			abma_pkg::ST_SCALE_GO: begin
				div_req.start = 1'b1;
				state_d       = abma_pkg::ST_SCALE_WAIT;
			end
			abma_pkg::ST_SCALE_WAIT: begin
				if (!div_busy) begin
					state_d = abma_pkg::ST_FINISH;
				end
			end
			abma_pkg::ST_FINISH: begin
				// Hold until the output register is free
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = abma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = abma_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= abma_pkg::FULL_SCALE_RST;
			adc_max_q    <= abma_pkg::ADC_MAX_RST;
			offset_q     <= abma_pkg::OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				abma_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data[abma_pkg::FS_W-1:0];
				abma_pkg::CFG_ADC_MAX:    adc_max_q    <= cfg_data[abma_pkg::ADC_W-1:0];
				abma_pkg::CFG_OFFSET:     offset_q     <= cfg_data[abma_pkg::VOLT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (s_acc) begin
			if (last) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_next;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && last) begin
			mean_q <= abma_pkg::ADC_W'(acc_next >> abma_pkg::HB_LOG);
		end
		if (state_q == abma_pkg::ST_AVG_WAIT && !div_busy) begin
			avg_q <= div_quo[abma_pkg::ADC_W-1:0];
		end
		if (state_q == abma_pkg::ST_MUL) begin
			prod_q <= prod_d;
			volt_q <= abma_pkg::VOLT_SAT;
		end
		if (state_q == abma_pkg::ST_SCALE_WAIT && !div_busy) begin
			volt_q <= volt_d;
		end
		if (load_out) begin
			m_tdata_q <= volt_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- hw/rtl/abma_chk.sv -----
module abma_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic [abma_pkg::CNT_W-1:0] seen_q;

	// Position of the next sample within its block, as seen on the ports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (s_tvalid && s_tready) begin
			if (seen_q == abma_pkg::CNT_W'(abma_pkg::HALF_BLOCK - 1)) begin
				seen_q <= '0;
			end else begin
				seen_q <= seen_q + 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && m_tvalid)
		else $error("voltage changed while stalled");

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid && s_tready))
		else $error("input side went busy without an item");

	a_busy_on_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(seen_q) == abma_pkg::CNT_W'(abma_pkg::HALF_BLOCK - 1))
		else $error("input side went busy before a block closed");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("voltage appeared without block processing");

endmodule

bind adc_block_and_moving_average_voltage abma_chk u_abma_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
